FILE: rtl/core/blm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad lag marker package
// Shared widths, codes, reset values and interface structs of the bad lag
// marker: the window datapath, the shared divider and the bad-sample list.
// ----------------------------------------------------------------------------
package blm_pkg;

	// Field widths.
	localparam int CFG_W = 16;
	localparam int LC_W  = 7;
	localparam int POS_W = 8;
	localparam int LAG_W = 8;
	localparam int LI_W  = 7;
	localparam int RG_W  = 10;
	localparam int SMP_W = 16;
	localparam int ST_W  = 2;
	localparam int IDX_W = 3;

	// List depth and the longest run of emitted samples per pulse.
	localparam int MAX_BAD = 64;
	localparam int MAX_RUN = 16;
	localparam int AW      = $clog2(MAX_BAD);
	localparam int BC_W    = $clog2(MAX_BAD + 1);

	// The marking loop never needs more passes than the larger of the two.
	localparam int LOOP_MAX = (MAX_BAD > MAX_RUN) ? MAX_BAD : MAX_RUN;
	localparam int M_W      = $clog2(LOOP_MAX + 1);

	// Window arithmetic: a pulse time is below 2^24, a sample time stays
	// below a window end plus one spacing, and window starts may go negative.
	localparam int PROD_W     = POS_W + CFG_W;
	localparam int DIV_W      = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int TS_W       = DIV_W + 1;
	localparam int TIME_W     = TS_W + 1;

	localparam int RX_DELAY = 100;
	localparam logic [LC_W-1:0] OLD_LAGS    = LC_W'(17);
	localparam logic [LI_W-1:0] OLD_BAD_LAG = LI_W'(13);

	// Register indexes of the write port.
	localparam logic [IDX_W-1:0] REG_LFD  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SPC  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_LEN  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_INC  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_LAGC = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_OLDF = IDX_W'(5);

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_LFD  = CFG_W'(1200);
	localparam logic [CFG_W-1:0] RST_SPC  = CFG_W'(300);
	localparam logic [CFG_W-1:0] RST_LEN  = CFG_W'(300);
	localparam logic [CFG_W-1:0] RST_INC  = CFG_W'(2400);
	localparam logic [LC_W-1:0]  RST_LAGC = LC_W'(18);
	localparam logic             RST_OLDF = 1'b0;

	// Opcodes and result kinds.
	localparam logic OP_PULSE   = 1'b0;
	localparam logic OP_QUERY   = 1'b1;
	localparam logic KIND_PULSE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_P_MUL,
		S_P_WIN,
		S_P_CHK,
		S_P_DIV1,
		S_P_DIV2,
		S_P_RUN,
		S_Q_DIV,
		S_Q_MUL,
		S_Q_ADD,
		S_Q_SCAN
	} state_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CFG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [CFG_W-1:0] rem;
	} div_rsp_t;

	// Bad-sample list access.
	typedef struct packed {
		logic             we;
		logic [AW-1:0]    waddr;
		logic [SMP_W-1:0] wdata;
		logic             re;
		logic [AW-1:0]    raddr;
	} ram_req_t;

endpackage

FILE: rtl/core/radar_bad_lag_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar bad lag marker
// Marks the samples blanked by each transmit pulse of a sequence, keeps them
// in a list, and answers whether a lag pair at a range gate hits one.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a clock edge with start high and busy low; busy stays
// high until the item's last result has been formed. A pulse item (opcode 0)
// yields one beat per marked sample, at most MAX_RUN of them, one per cycle,
// or none when its window lies behind the sample clock. A query (opcode 1)
// yields one beat. Each beat is shown for one cycle with strobe high, and
// last marks the final beat of the item. The receiver cannot stall.
// A pulse item passes the product, window and check states, then up to two
// divisions (catching up to the window, then counting its samples), then
// marks one sample per cycle, at most LOOP_MAX of them. A query takes one
// division, the product and sum states, then reads one list entry per cycle
// from the memory port until the early stop. Results leave through an
// output register, so each beat shows in the cycle after it is formed.
// With spacing and length both zero an item answers at once with status 1.
// Reset closes the sequence, empties the list and loads the register
// defaults; no clearing pass is needed.
// Registers are to be written through wr_en, wr_index and wr_data only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module radar_bad_lag_marker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [blm_pkg::POS_W-1:0]   pulse_position,
	input  logic                        last_pulse,
	input  logic [blm_pkg::LAG_W-1:0]   lag_first,
	input  logic [blm_pkg::LAG_W-1:0]   lag_second,
	input  logic [blm_pkg::LI_W-1:0]    lag_index,
	input  logic [blm_pkg::RG_W-1:0]    range_gate,
	output logic                        strobe,
	output logic [blm_pkg::SMP_W-1:0]   bad_sample,
	output logic                        lag_bad,
	output logic                        result_kind,
	output logic [blm_pkg::ST_W-1:0]    status,
	output logic                        last,
	input  logic                        wr_en,
	input  logic [blm_pkg::IDX_W-1:0]   wr_index,
	input  logic [blm_pkg::CFG_W-1:0]   wr_data
);
	import blm_pkg::*;

	// Registers and sequence state.
	logic [CFG_W-1:0] lfd_q, spc_q, len_q, inc_q;
	logic [LC_W-1:0]  lagc_q;
	logic             oldf_q;
	logic             open_q;
	logic [BC_W-1:0]  bc_q;
	logic [TS_W-1:0]  ts_q;
	logic [SMP_W-1:0] sn_q;
	state_t           state_q, state_d;

	// Item fields and working registers.
	logic [POS_W-1:0]         pos_q;
	logic                     lastp_q;
	logic [LAG_W-1:0]         l1_q, l2_q;
	logic [LI_W-1:0]          li_q;
	logic [RG_W-1:0]          rg_q;
	logic [PROD_W-1:0]        prod_q, prod2_q;
	logic signed [TIME_W-1:0] t1_q, t2_q, s1_q, s2_q;
	logic [CFG_W-1:0]         step_q;
	logic [M_W-1:0]           cnt_q, m_q;
	logic [SMP_W-1:0]         cnt16_q;
	logic [BC_W-1:0]          j_q;
	logic                     rv_q;
	logic                     hit_q;

	// Output register.
	logic             strobe_q;
	logic [SMP_W-1:0] smp_q;
	logic             bad_q;
	logic             kind_q;
	logic [ST_W-1:0]  st_q;
	logic             last_q;

	// Combinational signals.
	logic                     accept;
	logic [CFG_W-1:0]         sp;
	logic                     sp_zero;
	logic signed [TIME_W-1:0] ts_s, d1, d2, b_s;
	logic [TIME_W-1:0]        tsn1, tsn2;
	logic                     rnz;
	logic [M_W-1:0]           m_nx;
	logic [BC_W-1:0]          bc_nx;
	logic                     run_we, run_cont, run_last;
	logic [SMP_W-1:0]         idx;
	logic                     cur_hit, brk, scan_fin, ren, old_bad;
	logic                     emit, emit_bad, emit_kind, emit_last;
	logic [SMP_W-1:0]         emit_smp;
	logic [ST_W-1:0]          emit_st;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	ram_req_t                 ram_req;
	logic [SMP_W-1:0]         rdata;

	blm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	blm_list u_list (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// Handshake and effective sample spacing.
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign sp      = (spc_q != '0) ? spc_q : len_q;
	assign sp_zero = (sp == '0);

	// Window arithmetic against the sample clock.
	assign ts_s = {1'b0, ts_q};
	assign d1   = t1_q - ts_s;
	assign d2   = t2_q - ts_s;
	assign rnz  = (div_rsp.rem != '0);
	assign tsn1 = t1_q - TIME_W'(div_rsp.rem) + (rnz ? TIME_W'(sp) : '0);
	assign tsn2 = t2_q - TIME_W'(div_rsp.rem) + TIME_W'(sp);

	// Marking loop: one sample per cycle.
	assign m_nx     = m_q + M_W'(1);
	assign run_we   = (bc_q < BC_W'(MAX_BAD));
	assign bc_nx    = bc_q + (run_we ? BC_W'(1) : '0);
	assign run_last = (m_nx == cnt_q) || (m_nx == M_W'(MAX_RUN));
	assign run_cont = (m_nx < cnt_q) &&
		((m_nx < M_W'(MAX_RUN)) || (bc_nx < BC_W'(MAX_BAD)));
	assign idx      = sn_q + SMP_W'(m_q);

	// List scan with early stop once an entry passes the second sample.
	assign b_s      = TIME_W'(rdata);
	assign cur_hit  = rv_q && ((s1_q == b_s) || (s2_q == b_s));
	assign brk      = rv_q && (s2_q < b_s);
	assign scan_fin = (state_q == S_Q_SCAN) && (brk || (j_q >= bc_q));
	assign ren      = (state_q == S_Q_SCAN) && !scan_fin;
	assign old_bad  = (lagc_q == OLD_LAGS) && oldf_q && (li_q == OLD_BAD_LAG);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !sp_zero) begin
					state_d = (opcode == OP_PULSE) ? S_P_MUL : S_Q_DIV;
				end
			end
			S_P_MUL: state_d = S_P_WIN;
			S_P_WIN: state_d = S_P_CHK;
			S_P_CHK: begin
				if (ts_s > t2_q) begin
					state_d = S_IDLE;
				end else if (ts_s < t1_q) begin
					state_d = S_P_DIV1;
				end else begin
					state_d = S_P_DIV2;
				end
			end
			S_P_DIV1: if (div_rsp.done) state_d = S_P_CHK;
			S_P_DIV2: if (div_rsp.done) state_d = S_P_RUN;
			S_P_RUN:  if (!run_cont) state_d = S_IDLE;
			S_Q_DIV:  if (div_rsp.done) state_d = S_Q_MUL;
			S_Q_MUL:  state_d = S_Q_ADD;
			S_Q_ADD:  state_d = S_Q_SCAN;
			S_Q_SCAN: if (scan_fin) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// State outputs: divider start, list access and result beats.
	always_comb begin
		div_req   = '0;
		ram_req   = '0;
		emit      = 1'b0;
		emit_smp  = '0;
		emit_bad  = 1'b0;
		emit_kind = KIND_PULSE;
		emit_st   = ST_OK;
		emit_last = 1'b0;
		ram_req.waddr = bc_q[AW-1:0];
		ram_req.wdata = idx;
		ram_req.raddr = j_q[AW-1:0];
		div_req.divisor = sp;
		unique case (state_q)
			S_IDLE: begin
				if (accept && sp_zero) begin
					emit      = 1'b1;
					emit_kind = (opcode == OP_QUERY) ? KIND_QUERY : KIND_PULSE;
					emit_st   = ST_ZERO;
					emit_last = 1'b1;
				end else if (accept && (opcode == OP_QUERY)) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(inc_q);
				end
			end
			S_P_CHK: begin
				if (!(ts_s > t2_q)) begin
					div_req.start    = 1'b1;
					div_req.dividend = (ts_s < t1_q) ? d1[DIV_W-1:0] : d2[DIV_W-1:0];
				end
			end
			S_P_RUN: begin
				ram_req.we = run_we;
				if (m_q < M_W'(MAX_RUN)) begin
					emit      = 1'b1;
					emit_smp  = idx;
					emit_st   = run_we ? ST_OK : ST_FULL;
					emit_last = run_last;
				end
			end
			S_Q_SCAN: begin
				ram_req.re = ren;
				if (scan_fin) begin
					emit      = 1'b1;
					emit_kind = KIND_QUERY;
					emit_bad  = hit_q || cur_hit || old_bad;
					emit_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state, registers and sequence bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lfd_q    <= RST_LFD;
			spc_q    <= RST_SPC;
			len_q    <= RST_LEN;
			inc_q    <= RST_INC;
			lagc_q   <= RST_LAGC;
			oldf_q   <= RST_OLDF;
			open_q   <= 1'b0;
			bc_q     <= '0;
			ts_q     <= TS_W'(RST_LFD);
			sn_q     <= '0;
			j_q      <= '0;
			rv_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (wr_en) begin
				unique case (wr_index)
					REG_LFD:  lfd_q  <= wr_data;
					REG_SPC:  spc_q  <= wr_data;
					REG_LEN:  len_q  <= wr_data;
					REG_INC:  inc_q  <= wr_data;
					REG_LAGC: lagc_q <= wr_data[LC_W-1:0];
					REG_OLDF: oldf_q <= wr_data[0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_PULSE)) begin
						if (!open_q) begin
							bc_q   <= '0;
							ts_q   <= TS_W'(lfd_q);
							sn_q   <= '0;
							open_q <= 1'b1;
						end
						if (sp_zero && last_pulse) begin
							open_q <= 1'b0;
						end
					end
				end
				S_P_CHK: begin
					if ((ts_s > t2_q) && lastp_q) begin
						open_q <= 1'b0;
					end
				end
				S_P_DIV1: begin
					if (div_rsp.done) begin
						sn_q <= sn_q + div_rsp.quot[SMP_W-1:0] + {{(SMP_W-1){1'b0}}, rnz};
						ts_q <= tsn1[TS_W-1:0];
					end
				end
				S_P_DIV2: begin
					if (div_rsp.done) begin
						ts_q <= tsn2[TS_W-1:0];
					end
				end
				S_P_RUN: begin
					bc_q <= bc_nx;
					if (!run_cont) begin
						sn_q <= sn_q + cnt16_q;
						if (lastp_q) begin
							open_q <= 1'b0;
						end
					end
				end
				S_Q_ADD: begin
					j_q  <= '0;
					rv_q <= 1'b0;
				end
				S_Q_SCAN: begin
					if (ren) begin
						j_q <= j_q + BC_W'(1);
					end
					rv_q <= ren;
				end
				default: begin
				end
			endcase
		end
	end

	// Item fields, window values and the output beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= pulse_position;
			lastp_q <= last_pulse;
			l1_q    <= lag_first;
			l2_q    <= lag_second;
			li_q    <= lag_index;
			rg_q    <= range_gate;
		end
		case (state_q)
			S_P_MUL: prod_q <= pos_q * inc_q;
			S_P_WIN: begin
				t1_q <= TIME_W'(prod_q) - TIME_W'(len_q[CFG_W-1:1]);
				t2_q <= TIME_W'(prod_q) + TIME_W'(len_q) + TIME_W'(RX_DELAY);
			end
			S_P_DIV2: begin
				if (div_rsp.done) begin
					cnt_q   <= (div_rsp.quot >= DIV_W'(LOOP_MAX)) ? M_W'(LOOP_MAX) :
						div_rsp.quot[M_W-1:0] + M_W'(1);
					cnt16_q <= div_rsp.quot[SMP_W-1:0] + SMP_W'(1);
					m_q     <= '0;
				end
			end
			S_P_RUN: m_q <= m_nx;
			S_Q_DIV: begin
				if (div_rsp.done) begin
					step_q <= div_rsp.quot[CFG_W-1:0];
				end
			end
			S_Q_MUL: begin
				prod_q  <= l1_q * step_q;
				prod2_q <= l2_q * step_q;
			end
			S_Q_ADD: begin
				s1_q  <= TIME_W'(prod_q) + TIME_W'(rg_q) - TIME_W'(1);
				s2_q  <= TIME_W'(prod2_q) + TIME_W'(rg_q) - TIME_W'(1);
				hit_q <= 1'b0;
			end
			S_Q_SCAN: if (cur_hit) hit_q <= 1'b1;
			default: begin
			end
		endcase
		if (emit) begin
			smp_q  <= emit_smp;
			bad_q  <= emit_bad;
			kind_q <= emit_kind;
			st_q   <= emit_st;
			last_q <= emit_last;
		end
	end

	assign strobe      = strobe_q;
	assign bad_sample  = smp_q;
	assign lag_bad     = bad_q;
	assign result_kind = kind_q;
	assign status      = st_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	// A beat that is not the last of its item is always followed by another.
	assert property (@(posedge clk) disable iff (!arst_n) strobe && !last |=> strobe)
		else $error("result run broken before its last beat");

	// The divider is never started with a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("divider started with zero divisor");

	// The list is written only below its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (bc_q < BC_W'(MAX_BAD)))
		else $error("write beyond the end of the sample list");

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n) bc_q <= BC_W'(MAX_BAD))
		else $error("sample list count overflow");
`endif

endmodule

FILE: rtl/core/blm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad lag marker divider
// Restoring divider, one quotient bit per cycle; the result is valid with
// the done pulse.
// ----------------------------------------------------------------------------
module blm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  blm_pkg::div_req_t   req,
	output blm_pkg::div_rsp_t   rsp
);
	import blm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CFG_W-1:0]     rem_q;
	logic [CFG_W-1:0]     dsr_q;
	logic [CFG_W:0]       shifted;
	logic [CFG_W:0]       diff;

	// Shift in the next dividend bit and try the subtraction.
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	// Control: busy while iterating, done for one cycle at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient share one shift register pair.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[CFG_W]) begin
				rem_q <= diff[CFG_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CFG_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/core/blm_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad lag marker sample list
// Single-port-write, single-port-read memory of marked sample indices with
// registered read data.
// ----------------------------------------------------------------------------
module blm_list (
	input  logic                        clk,
	input  blm_pkg::ram_req_t           req,
	output logic [blm_pkg::SMP_W-1:0]   rdata
);
	import blm_pkg::*;

	logic [SMP_W-1:0] mem [MAX_BAD];
	logic [SMP_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/sv/tb_radar_bad_lag_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar bad lag marker testbench
// Drives pulse and lag-query beats into the marker while the settings change
// between phases. A scoreboard inside the testbench predicts every result
// beat from its own copy of the window, sample clock and bad-sample list, and
// compares each strobed beat field by field in order. Directed checks come
// first, then random pulse sequences with queries, stray items and idle bursts.
// ----------------------------------------------------------------------------
module tb_radar_bad_lag_marker;
	import blm_pkg::*;

	localparam int ITEMS_TOTAL = 265;
	localparam int QUIET_TAIL  = 40;
	localparam int SETTLE      = 150;
	localparam int DRAIN       = 200;
	localparam int LIMIT_NS    = 5_000_000;

	// One queued beat for the driver: an item or a register write.
	typedef struct {
		logic              is_reg;
		int                hold;
		logic              hold_idle;
		logic [IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]  reg_val;
		logic              op;
		logic [POS_W-1:0]  pos;
		logic              lastp;
		logic [LAG_W-1:0]  l1;
		logic [LAG_W-1:0]  l2;
		logic [LI_W-1:0]   li;
		logic [RG_W-1:0]   rg;
	} marker_cmd_t;

	// One predicted result beat.
	typedef struct {
		logic [SMP_W-1:0] smp;
		logic             bad;
		logic             kind;
		status_t          st;
		logic             last;
	} marker_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = OP_PULSE;
	logic [POS_W-1:0] pulse_position = '0;
	logic last_pulse = 1'b0;
	logic [LAG_W-1:0] lag_first = '0;
	logic [LAG_W-1:0] lag_second = '0;
	logic [LI_W-1:0] lag_index = '0;
	logic [RG_W-1:0] range_gate = '0;
	logic strobe;
	logic [SMP_W-1:0] bad_sample;
	logic lag_bad;
	logic result_kind;
	logic [ST_W-1:0] status;
	logic last;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = REG_LFD;
	logic [CFG_W-1:0] wr_data = '0;

	radar_bad_lag_marker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.pulse_position(pulse_position),
		.last_pulse(last_pulse),
		.lag_first(lag_first),
		.lag_second(lag_second),
		.lag_index(lag_index),
		.range_gate(range_gate),
		.strobe(strobe),
		.bad_sample(bad_sample),
		.lag_bad(lag_bad),
		.result_kind(result_kind),
		.status(status),
		.last(last),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Scoreboard copy of the settings and the marking state.
	logic [CFG_W-1:0] cfg_lfd, cfg_spc, cfg_len, cfg_inc;
	logic [LC_W-1:0]  cfg_lagc;
	logic             cfg_oldf;
	logic [SMP_W-1:0] marks [MAX_BAD];
	int               mark_cnt;
	logic [31:0]      smp_time;
	logic [SMP_W-1:0] smp_num;
	logic             seq_open;

	marker_cmd_t    cmd_q [$];
	marker_result_t awaited [$];
	marker_result_t want;
	int             awaited_n = 0;

	int miss_cnt = 0;
	int n_items = 0;
	int n_pulse = 0, n_query = 0, n_writes = 0, n_checked = 0;
	int n_full = 0, n_zero = 0, n_lagbad = 0;
	bit idle_on = 1'b1;
	int seq_pos [$];

	// Driver scratch state.
	int   wait_cnt = 0;
	logic took, go_start, go_write;

	function automatic marker_result_t make_result(input logic [SMP_W-1:0] smp,
			input logic bad, input logic kind, input status_t st, input logic fin);
		marker_result_t r;
		r.smp  = smp;
		r.bad  = bad;
		r.kind = kind;
		r.st   = st;
		r.last = fin;
		return r;
	endfunction

	task automatic note_miss(input string msg);
		miss_cnt++;
		if (miss_cnt <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Marks the samples that fall inside one pulse's blanking window.
	task automatic mark_pulse_window(input logic [POS_W-1:0] pos, input logic lastp);
		longint sp, ts, t1, t2, n, cnt, m;
		status_t st;
		marker_result_t run_q [$];
		sp = (cfg_spc != '0) ? longint'(cfg_spc) : longint'(cfg_len);
		if (!seq_open) begin
			mark_cnt = 0;
			smp_time = 32'(cfg_lfd);
			smp_num  = '0;
			seq_open = 1'b1;
		end
		if (sp == 0) begin
			run_q.push_back(make_result('0, 1'b0, KIND_PULSE, ST_ZERO, 1'b1));
		end else begin
			ts = longint'(smp_time);
			t1 = longint'(pos) * longint'(cfg_inc) - longint'(cfg_len / 2);
			t2 = t1 + (longint'(cfg_len) * 3) / 2 + RX_DELAY;
			if (ts <= t2) begin
				// Catch the sample clock up to the window start.
				if (ts < t1) begin
					n = (t1 - ts + sp - 1) / sp;
					smp_num = smp_num + 16'(n);
					ts = ts + n * sp;
				end
				if (ts <= t2) begin
					cnt = (t2 - ts) / sp + 1;
					for (m = 0; m < cnt; m++) begin
						st = ST_OK;
						if (mark_cnt < MAX_BAD) begin
							marks[mark_cnt] = smp_num + 16'(m);
							mark_cnt++;
						end else begin
							st = ST_FULL;
						end
						if (m < MAX_RUN) begin
							run_q.push_back(make_result(smp_num + 16'(m), 1'b0,
								KIND_PULSE, st, 1'b0));
						end else if (mark_cnt >= MAX_BAD) begin
							break;
						end
					end
					smp_num = smp_num + 16'(cnt);
					ts = ts + cnt * sp;
				end
				smp_time = 32'(ts);
			end
			if (run_q.size() != 0) begin
				run_q[run_q.size() - 1].last = 1'b1;
			end
		end
		if (lastp) begin
			seq_open = 1'b0;
		end
		foreach (run_q[i]) begin
			awaited.push_back(run_q[i]);
		end
	endtask

	// Answers whether a lag pair at a range gate lands on a marked sample.
	task automatic check_lag_pair(input logic [LAG_W-1:0] l1, input logic [LAG_W-1:0] l2,
			input logic [LI_W-1:0] li, input logic [RG_W-1:0] rg);
		longint sp, step, s1, s2, b;
		logic hit;
		sp = (cfg_spc != '0) ? longint'(cfg_spc) : longint'(cfg_len);
		if (sp == 0) begin
			awaited.push_back(make_result('0, 1'b0, KIND_QUERY, ST_ZERO, 1'b1));
		end else begin
			step = longint'(cfg_inc) / sp;
			s1 = longint'(l1) * step + longint'(rg) - 1;
			s2 = longint'(l2) * step + longint'(rg) - 1;
			hit = 1'b0;
			// The list scan stops after the first entry above the second sample.
			for (int j = 0; j < mark_cnt; j++) begin
				b = longint'(marks[j]);
				if (s1 == b || s2 == b) begin
					hit = 1'b1;
				end
				if (s2 < b) begin
					break;
				end
			end
			if (cfg_lagc == OLD_LAGS && cfg_oldf && li == OLD_BAD_LAG) begin
				hit = 1'b1;
			end
			awaited.push_back(make_result('0, hit, KIND_QUERY, ST_OK, 1'b1));
		end
	endtask

	// A beat with random content in the fields that its kind ignores.
	function automatic marker_cmd_t blank_cmd();
		marker_cmd_t c;
		c.is_reg    = 1'b0;
		c.reg_idx   = REG_LFD;
		c.reg_val   = '0;
		c.op        = OP_PULSE;
		c.pos       = POS_W'($urandom);
		c.lastp     = 1'($urandom);
		c.l1        = LAG_W'($urandom);
		c.l2        = LAG_W'($urandom);
		c.li        = LI_W'($urandom);
		c.rg        = RG_W'($urandom);
		c.hold      = 0;
		c.hold_idle = 1'b0;
		if (idle_on && n_items < ITEMS_TOTAL - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
			c.hold      = $urandom_range(1, 15);
			c.hold_idle = 1'($urandom_range(0, 1));
		end
		return c;
	endfunction

	task automatic add_pulse(input int pos, input bit lastp);
		marker_cmd_t c;
		c = blank_cmd();
		c.op    = OP_PULSE;
		c.pos   = POS_W'(pos);
		c.lastp = lastp;
		cmd_q.push_back(c);
		n_items++;
	endtask

	task automatic add_query(input int l1, input int l2, input int li, input int rg);
		marker_cmd_t c;
		c = blank_cmd();
		c.op = OP_QUERY;
		c.l1 = LAG_W'(l1);
		c.l2 = LAG_W'(l2);
		c.li = LI_W'(li);
		c.rg = RG_W'(rg);
		cmd_q.push_back(c);
		n_items++;
	endtask

	// The first write of a phase waits for the block to go quiet.
	task automatic add_reg(input logic [IDX_W-1:0] idx, input int val, input bit settle);
		marker_cmd_t c;
		c = blank_cmd();
		c.is_reg  = 1'b1;
		c.reg_idx = idx;
		c.reg_val = CFG_W'(val);
		c.hold    = settle ? SETTLE : 0;
		cmd_q.push_back(c);
	endtask

	task automatic write_regs(input int lfd, input int spc, input int len, input int inc,
			input int lagc, input int oldf);
		add_reg(REG_LFD, lfd, 1'b1);
		add_reg(REG_SPC, spc, 1'b0);
		add_reg(REG_LEN, len, 1'b0);
		add_reg(REG_INC, inc, 1'b0);
		add_reg(REG_LAGC, lagc, 1'b0);
		add_reg(REG_OLDF, oldf, 1'b0);
	endtask

	// A query whose lag pair mostly comes from the current pulse sequence.
	task automatic add_lag_query();
		int a, b, t, li, rg;
		if (seq_pos.size() == 0 || $urandom_range(0, 4) == 0) begin
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
		end else begin
			a = seq_pos[$urandom_range(0, seq_pos.size() - 1)];
			b = seq_pos[$urandom_range(0, seq_pos.size() - 1)];
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
		end
		li = ($urandom_range(0, 3) == 0) ? int'(OLD_BAD_LAG) : $urandom_range(0, 127);
		case ($urandom_range(0, 9))
			0: begin
				rg = 0;
			end
			1, 2: begin
				rg = $urandom_range(1, 1023);
			end
			default: begin
				rg = $urandom_range(1, 64);
			end
		endcase
		add_query(a, b, li, rg);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: presents queued beats, holding each item until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			wr_en <= 1'b0;
			wait_cnt = 0;
		end else begin
			took = 1'b0;
			if ((start && !busy) || wr_en) begin
				cmd_q.delete(0);
				wait_cnt = 0;
				took = 1'b1;
			end
			go_start = start && busy;
			go_write = 1'b0;
			if (!go_start && cmd_q.size() != 0) begin
				if (cmd_q[0].is_reg) begin
					// Registers change only with the block idle and nothing owed.
					if (!took && !busy && awaited_n == 0) begin
						if (wait_cnt >= cmd_q[0].hold) begin
							go_write = 1'b1;
						end else begin
							wait_cnt++;
						end
					end
				end else if (wait_cnt >= cmd_q[0].hold) begin
					go_start = 1'b1;
					opcode         <= cmd_q[0].op;
					pulse_position <= cmd_q[0].pos;
					last_pulse     <= cmd_q[0].lastp;
					lag_first      <= cmd_q[0].l1;
					lag_second     <= cmd_q[0].l2;
					lag_index      <= cmd_q[0].li;
					range_gate     <= cmd_q[0].rg;
				end else if (!cmd_q[0].hold_idle || !busy) begin
					wait_cnt++;
				end
			end
			if (go_write) begin
				wr_index <= cmd_q[0].reg_idx;
				wr_data  <= cmd_q[0].reg_val;
			end
			start <= go_start;
			wr_en <= go_write;
		end
	end

	// Monitor: checks result beats, then tracks writes and accepted items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lfd  = RST_LFD;
			cfg_spc  = RST_SPC;
			cfg_len  = RST_LEN;
			cfg_inc  = RST_INC;
			cfg_lagc = RST_LAGC;
			cfg_oldf = RST_OLDF;
			mark_cnt = 0;
			smp_time = 32'(RST_LFD);
			smp_num  = '0;
			seq_open = 1'b0;
			awaited.delete();
			awaited_n <= 0;
		end else begin
			if (strobe) begin
				if (awaited.size() == 0) begin
					note_miss($sformatf("unexpected result: smp=%0d bad=%0d kind=%0d st=%0d last=%0d",
						bad_sample, lag_bad, result_kind, status, last));
				end else begin
					want = awaited.pop_front();
					n_checked++;
					if (want.st == ST_FULL) n_full++;
					if (want.st == ST_ZERO) n_zero++;
					if (want.bad) n_lagbad++;
					if (bad_sample !== want.smp || lag_bad !== want.bad
							|| result_kind !== want.kind || status !== want.st
							|| last !== want.last) begin
						note_miss($sformatf({"result %0d mismatch: expected smp=%0d bad=%0d ",
							"kind=%0d st=%0d last=%0d, got smp=%0d bad=%0d kind=%0d st=%0d ",
							"last=%0d"}, n_checked, want.smp, want.bad, want.kind, want.st,
							want.last, bad_sample, lag_bad, result_kind, status, last));
					end
				end
			end
			if (wr_en) begin
				n_writes++;
				case (wr_index)
					REG_LFD: begin
						cfg_lfd = wr_data;
					end
					REG_SPC: begin
						cfg_spc = wr_data;
					end
					REG_LEN: begin
						cfg_len = wr_data;
					end
					REG_INC: begin
						cfg_inc = wr_data;
					end
					REG_LAGC: begin
						cfg_lagc = wr_data[LC_W-1:0];
					end
					REG_OLDF: begin
						cfg_oldf = wr_data[0];
					end
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				if (opcode == OP_PULSE) begin
					n_pulse++;
					mark_pulse_window(pulse_position, last_pulse);
				end else begin
					n_query++;
					check_lag_pair(lag_first, lag_second, lag_index, range_gate);
				end
			end
			awaited_n <= awaited.size();
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stim
		int lfd, spc, len, inc, lagc, oldf, nseq, npul, pos;
		// Defaults: a sequence opening on a skipped pulse, a far pulse, queries.
		add_pulse(0, 1'b0);
		add_pulse(1, 1'b0);
		add_pulse(9, 1'b0);
		add_pulse(12, 1'b0);
		add_query(1, 9, 0, 1);
		add_pulse(255, 1'b1);
		add_query(0, 255, 127, 1023);
		add_query(0, 0, 0, 0);
		add_query(0, 1, 5, 5);
		// Old seventeen-lag mode forces lag thirteen bad.
		add_reg(REG_LAGC, int'(OLD_LAGS), 1'b1);
		add_reg(REG_OLDF, 1, 1'b0);
		add_query(2, 3, int'(OLD_BAD_LAG), 300);
		add_query(2, 3, 12, 300);
		// Zero spacing falls back to the pulse length.
		add_reg(REG_SPC, 0, 1'b1);
		add_pulse(3, 1'b1);
		add_query(0, 3, 1, 21);
		// Spacing and length both zero.
		add_reg(REG_LEN, 0, 1'b1);
		add_pulse(7, 1'b1);
		add_query(7, 7, int'(OLD_BAD_LAG), 1);
		// Long runs that overflow the list.
		write_regs(1200, 10, 300, 2400, 0, 0);
		add_pulse(1, 1'b0);
		add_pulse(2, 1'b1);
		add_query(1, 2, int'(OLD_BAD_LAG), 10);
		// Largest settings: the sample counter wraps while catching up.
		write_regs(65535, 1, 0, 65535, 127, 1);
		add_pulse(255, 1'b1);
		add_query(255, 255, 127, 1023);
		// Smallest delay and increment with the widest window.
		write_regs(1, 65535, 65535, 1, int'(OLD_LAGS), 0);
		add_pulse(0, 1'b0);
		add_pulse(255, 1'b1);
		add_query(0, 255, int'(OLD_BAD_LAG), 1);

		// Random phases: new settings, then sequences, queries and stray items.
		while (n_items < ITEMS_TOTAL) begin
			idle_on = ($urandom_range(0, 3) != 0);
			lagc = $urandom_range(0, 1) ? int'(OLD_LAGS) : $urandom_range(0, 127);
			oldf = $urandom_range(0, 1);
			case ($urandom_range(0, 4))
				0: begin
					lfd = $urandom_range(600, 3000);
					spc = $urandom_range(100, 600);
					len = $urandom_range(50, 600);
					inc = $urandom_range(1500, 4000);
				end
				1: begin
					lfd = $urandom_range(100, 3000);
					spc = $urandom_range(1, 40);
					len = $urandom_range(100, 600);
					inc = $urandom_range(1000, 4000);
				end
				2: begin
					lfd = $urandom_range(600, 3000);
					spc = 0;
					len = $urandom_range(100, 600);
					inc = $urandom_range(1500, 4000);
				end
				3: begin
					lfd = $urandom_range(1, 65535);
					spc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
					len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
					inc = $urandom_range(1, 65535);
				end
				default: begin
					lfd = $urandom_range(0, 1) ? 1 : 65535;
					case ($urandom_range(0, 2))
						0: spc = 0;
						1: spc = 1;
						default: spc = 65535;
					endcase
					len = $urandom_range(0, 1) ? 0 : 65535;
					inc = $urandom_range(0, 1) ? 1 : 65535;
				end
			endcase
			write_regs(lfd, spc, len, inc, lagc, oldf);
			nseq = $urandom_range(1, 3);
			for (int s = 0; s < nseq && n_items < ITEMS_TOTAL; s++) begin
				if ($urandom_range(0, 5) == 0) begin
					// Stray items out of any orderly sequence.
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1)) begin
							add_pulse($urandom_range(0, 255), 1'($urandom_range(0, 1)));
						end else begin
							add_query($urandom_range(0, 255), $urandom_range(0, 255),
								$urandom_range(0, 127), $urandom_range(0, 1023));
						end
					end
				end else begin
					// A rising pulse sequence, sometimes left open.
					npul = $urandom_range(2, 8);
					pos = $urandom_range(0, 24);
					seq_pos.delete();
					for (int k = 0; k < npul; k++) begin
						seq_pos.push_back(pos);
						add_pulse(pos, k == npul - 1 && $urandom_range(0, 7) != 0);
						if ($urandom_range(0, 4) == 0) begin
							add_lag_query();
						end
						pos = pos + $urandom_range(1, 12);
						if (pos > 255) pos = 255;
					end
					repeat ($urandom_range(1, 5)) add_lag_query();
				end
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || awaited_n != 0 || busy || start) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (awaited.size() != 0) begin
			miss_cnt += awaited.size() - 1;
			note_miss($sformatf("%0d expected results never arrived", awaited.size()));
		end
		$display("Covered %0d pulse items and %0d lag queries across %0d register writes.",
			n_pulse, n_query, n_writes);
		$display("Checked %0d results: %0d list full, %0d zero spacing, %0d lags bad; %0d errors.",
			n_checked, n_full, n_zero, n_lagbad, miss_cnt);
		if (miss_cnt == 0) begin
			$display("PASS radar_bad_lag_marker");
		end else begin
			$display("FAIL radar_bad_lag_marker");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#LIMIT_NS;
		$display("FAIL radar_bad_lag_marker");
		$finish;
	end

endmodule
